>>> hw/rtl/hst_pkg.sv
// Shared types, constants and helper functions for the hand slot tracker.
package hst_pkg;

    // Q1.15 fixed-point constants.
    localparam logic [15:0] Q_ONE  = 16'd32768;
    localparam logic [15:0] Q_HALF = 16'd16384;
    localparam logic [14:0] W_OLD  = 15'd22938;
    localparam logic [13:0] W_NEW  = 14'd9830;

    // Width of the pre-weighted new score (32768 * 9830 fits in 29 bits).
    localparam int SCORE_W_BITS = 29;

    // Default number of tracking slots.
    localparam int SLOT_COUNT_DEF = 2;

    // Configuration register indexes.
    localparam int CFG_IDX_BITS = 8;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PRESENCE_THRESHOLD = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LOST_FRAME_LIMIT   = 8'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SWITCH_FRAME_LIMIT = 8'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FLIP_SIDE          = 8'd3;

    // Configuration register reset values.
    localparam logic [15:0] PRESENCE_THRESHOLD_RST = 16'd16384;
    localparam logic [7:0]  LOST_FRAME_LIMIT_RST   = 8'd5;
    localparam logic [7:0]  SWITCH_FRAME_LIMIT_RST = 8'd5;

    // Per-slot tracking state.
    typedef struct packed {
        logic        slot_on;
        logic        side_set;
        logic        side_bit;
        logic [15:0] smoothed_score;
        logic [7:0]  contradiction_count;
        logic [7:0]  low_presence_count;
        logic [15:0] last_presence;
    } slot_state_t;

    // Configuration register file.
    typedef struct packed {
        logic [15:0] presence_threshold;
        logic [7:0]  lost_frame_limit;
        logic [7:0]  switch_frame_limit;
        logic        flip_side;
    } hst_cfg_t;

    // Fields of one result item, apart from the slot number.
    typedef struct packed {
        logic        active;
        logic        side_known;
        logic        side_right;
        logic [15:0] right_prob;
        logic [15:0] presence;
    } hst_result_t;

    // Clamp a Q1.15 value to 1.0.
    function automatic logic [15:0] sat_q(input logic [15:0] v);
        return (v > Q_ONE) ? Q_ONE : v;
    endfunction

    // Right probability of a smoothed score, optionally mirrored.
    function automatic logic [15:0] prob_of(input logic [15:0] s, input logic flip);
        logic [16:0] diff;
        diff = {1'b0, Q_ONE} - {1'b0, s};
        return flip ? diff[15:0] : s;
    endfunction

    // Saturating increment of an 8-bit frame counter.
    function automatic logic [7:0] sat_inc8(input logic [7:0] c);
        return (c == 8'hFF) ? c : c + 8'd1;
    endfunction

endpackage

>>> hw/rtl/hand_slot_presence_and_side_tracker_unit.sv
// Top level of the hand slot presence and side tracker.
// Pipeline: a result passes from the input stage register into the output register.
// Throughput: one item per cycle while out_stall does not hold the output register; the slot
// state registers are updated in the same cycle that the result register loads, so consecutive
// items on one slot chain directly. Reset: rst_n clears all slots to inactive, empties both
// pipeline stages and loads the configuration registers with their default values.
module hand_slot_presence_and_side_tracker_unit
    import hst_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // Input channel
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    slot_index,
    input  logic                    start_track,
    input  logic                    speculative,
    input  logic                    result_valid,
    input  logic [15:0]             presence_in,
    input  logic [15:0]             hand_score_in,
    // Output channel
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    slot_out,
    output logic                    slot_active,
    output logic                    side_known,
    output logic                    side_right,
    output logic [15:0]             right_prob,
    output logic [15:0]             presence_out,
    // Configuration write channel
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [15:0]             cfg_data
);

    hst_cfg_t                cfg_reg;
    slot_state_t             slot_reg [SLOT_COUNT];

    logic                    s1_valid_reg;
    logic                    s1_slot_reg;
    logic                    s1_start_reg;
    logic                    s1_spec_reg;
    logic                    s1_rv_reg;
    logic [15:0]             s1_pres_reg;
    logic [15:0]             s1_score_reg;
    logic [SCORE_W_BITS-1:0] s1_score_w_reg;

    logic                    out_valid_reg;
    logic                    out_slot_reg;
    hst_result_t             out_result_reg;

    logic                    advance;
    logic                    in_fire;
    logic                    in_range;
    logic [15:0]             score_sat;
    slot_state_t             cur_state;
    slot_state_t             next_state;
    hst_result_t             upd_result;
    hst_result_t             result_next;

    // The output register takes a new result when it is empty or being drained.
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign in_fire  = in_valid && !in_stall;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.presence_threshold <= PRESENCE_THRESHOLD_RST;
            cfg_reg.lost_frame_limit   <= LOST_FRAME_LIMIT_RST;
            cfg_reg.switch_frame_limit <= SWITCH_FRAME_LIMIT_RST;
            cfg_reg.flip_side          <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_PRESENCE_THRESHOLD: cfg_reg.presence_threshold <= cfg_data;
                CFG_LOST_FRAME_LIMIT:   cfg_reg.lost_frame_limit   <= cfg_data[7:0];
                CFG_SWITCH_FRAME_LIMIT: cfg_reg.switch_frame_limit <= cfg_data[7:0];
                CFG_FLIP_SIDE:          cfg_reg.flip_side          <= cfg_data[0];
                default:                ;
            endcase
        end
    end

    // Input stage: saturate the Q1.15 fields and pre-weight the new score.
    assign score_sat = sat_q(hand_score_in);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_slot_reg    <= slot_index;
            s1_start_reg   <= start_track;
            s1_spec_reg    <= speculative;
            s1_rv_reg      <= result_valid;
            s1_pres_reg    <= sat_q(presence_in);
            s1_score_reg   <= score_sat;
            s1_score_w_reg <= score_sat * W_NEW;
        end
    end

    // Read the addressed slot; an out-of-range slot reads as cleared.
    assign in_range = (32'(s1_slot_reg) < SLOT_COUNT);

    always_comb
    begin
        cur_state = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (32'(i) == 32'(s1_slot_reg))
            begin
                cur_state = slot_reg[i];
            end
        end
    end

    hst_slot_update u_update (
        .cur_state      (cur_state),
        .start_track    (s1_start_reg),
        .speculative    (s1_spec_reg),
        .result_valid   (s1_rv_reg),
        .presence       (s1_pres_reg),
        .score          (s1_score_reg),
        .score_weighted (s1_score_w_reg),
        .cfg            (cfg_reg),
        .next_state     (next_state),
        .result         (upd_result)
    );

    assign result_next = in_range ? upd_result : '0;

    // Slot state write-back, in the same cycle as the result transfer into the output.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slot_reg[i] <= '0;
            end
        end
        else if (s1_valid_reg && advance)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                if (32'(i) == 32'(s1_slot_reg))
                begin
                    slot_reg[i] <= next_state;
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && advance)
        begin
            out_slot_reg   <= s1_slot_reg;
            out_result_reg <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign slot_out     = out_slot_reg;
    assign slot_active  = out_result_reg.active;
    assign side_known   = out_result_reg.side_known;
    assign side_right   = out_result_reg.side_right;
    assign right_prob   = out_result_reg.right_prob;
    assign presence_out = out_result_reg.presence;

endmodule

>>> hw/rtl/hst_slot_update.sv
// Single-pass update of one slot's state for one landmark result.
module hst_slot_update
    import hst_pkg::*;
(
    input  slot_state_t              cur_state,
    input  logic                     start_track,
    input  logic                     speculative,
    input  logic                     result_valid,
    input  logic [15:0]              presence,
    input  logic [15:0]              score,
    input  logic [SCORE_W_BITS-1:0]  score_weighted,
    input  hst_cfg_t                 cfg,
    output slot_state_t              next_state,
    output hst_result_t              result
);

    logic [30:0] old_weighted;
    logic [31:0] smooth_sum;
    logic [16:0] smooth_shift;
    logic [15:0] smooth_val;
    logic        low_frame;

    // Smoothing: 0.7 of the old score plus 0.3 of the new, rounded half up.
    assign old_weighted = cur_state.smoothed_score * W_OLD;
    assign smooth_sum   = 32'(old_weighted) + 32'(score_weighted) + 32'(Q_HALF);
    assign smooth_shift = smooth_sum[31:15];
    assign smooth_val   = (smooth_shift > 17'(Q_ONE)) ? Q_ONE : smooth_shift[15:0];

    assign low_frame = (presence < cfg.presence_threshold);

    // Slot state transition.
    always_comb
    begin
        slot_state_t st;
        logic        dropped;
        logic [7:0]  cnt;
        logic        cand;

        st      = cur_state;
        dropped = 1'b0;
        cnt     = '0;
        cand    = 1'b0;

        if (start_track)
        begin
            st         = '0;
            st.slot_on = 1'b1;
        end

        if (st.slot_on)
        begin
            if (!result_valid || (start_track && speculative && low_frame))
            begin
                st = '0;
            end
            else
            begin
                st.last_presence = presence;
                st.smoothed_score = st.side_set ? smooth_val : score;

                // Count low-presence frames and drop the slot at the limit.
                if (low_frame)
                begin
                    cnt = sat_inc8(st.low_presence_count);
                    st.low_presence_count = cnt;
                    if (cnt >= cfg.lost_frame_limit)
                    begin
                        st      = '0;
                        dropped = 1'b1;
                    end
                end
                else
                begin
                    st.low_presence_count = '0;
                end

                // Sticky side with hysteresis on contradicting frames.
                if (!dropped)
                begin
                    cand = (prob_of(st.smoothed_score, cfg.flip_side) > Q_HALF);
                    if (!st.side_set)
                    begin
                        st.side_bit            = cand;
                        st.side_set            = 1'b1;
                        st.contradiction_count = '0;
                    end
                    else if (cand != st.side_bit)
                    begin
                        cnt = sat_inc8(st.contradiction_count);
                        st.contradiction_count = cnt;
                        if (cnt >= cfg.switch_frame_limit)
                        begin
                            st.side_bit            = cand;
                            st.contradiction_count = '0;
                        end
                    end
                    else
                    begin
                        st.contradiction_count = '0;
                    end
                end
            end
        end

        next_state = st;
    end

    // Result fields read zero unless the slot is still tracking.
    always_comb
    begin
        result = '0;
        if (next_state.slot_on)
        begin
            result.active     = 1'b1;
            result.side_known = next_state.side_set;
            result.side_right = next_state.side_bit;
            result.right_prob = prob_of(next_state.smoothed_score, cfg.flip_side);
            result.presence   = next_state.last_presence;
        end
    end

endmodule

>>> hw/rtl/hst_checker.sv
// Port-level checker for the hand slot tracker, bound to the top level.
module hst_checker
    import hst_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        slot_active,
    input logic        side_known,
    input logic [15:0] right_prob,
    input logic [15:0] presence_out
);

    // A stalled result stays valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its probability and presence.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(right_prob) && $stable(presence_out))
        else $error("stalled result payload changed");

    // Every input transfer is expected to be followed by a valid result at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> ##2 out_valid)
        else $error("accepted item did not reach the output");

    // An inactive slot reports no side, probability or presence.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !slot_active |-> !side_known && right_prob == 16'd0
            && presence_out == 16'd0)
        else $error("inactive slot reported nonzero fields");

    // A known side is only reported for an active slot whose probability and presence are in range.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && side_known |-> slot_active && right_prob <= Q_ONE
            && presence_out <= Q_ONE)
        else $error("side reported on an inactive slot or value out of range");

endmodule

bind hand_slot_presence_and_side_tracker_unit hst_checker u_hst_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .slot_active   (slot_active),
    .side_known    (side_known),
    .right_prob    (right_prob),
    .presence_out  (presence_out)
);
